// ----- sv/assert_macros.svh -----
// Assertion helper macros used by the sprite blit RTL.
// Needs signals named clock and reset (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBPE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbpe assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SBPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbpe assertion failed");

`endif

// ----- sv/sbpe_pkg.sv -----
// Shared types and constants of the sprite blit pixel engine.
// No dependencies; used by every sbpe module except sbpe_ram.
`timescale 1ns / 1ps
`default_nettype none

package sbpe_pkg;

   localparam int ATLAS_DEPTH = 65536;
   localparam int ATLAS_AW    = 16;
   localparam int COLOR_W     = 16;
   localparam int FB_W        = 18;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SRC_W       = 18;  // step * inv_scale >> 16

   localparam logic [COLOR_W-1:0] BLACK_565 = 16'h0000;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_OPAQUE  = 2'd0,
      MODE_KEYED   = 2'd1,
      MODE_RECOLOR = 2'd2,
      MODE_SCALED  = 2'd3
   } draw_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAW_MODE  = 3'd0,
      CSR_SPRITE_X   = 3'd1,
      CSR_SPRITE_Y   = 3'd2,
      CSR_SPRITE_W   = 3'd3,
      CSR_SPRITE_H   = 3'd4,
      CSR_SWAP_COLOR = 3'd5,
      CSR_INV_SCALE  = 3'd6,
      CSR_KEY_COLOR  = 3'd7
   } csr_index_type;

   typedef struct packed {
      draw_mode_type        draw_mode;
      logic [7:0]           sprite_x;
      logic [7:0]           sprite_y;
      logic [8:0]           sprite_w;
      logic [8:0]           sprite_h;
      logic [COLOR_W-1:0]   swap_color;
      logic [23:0]          inv_scale;
      logic [COLOR_W-1:0]   key_color;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      draw_mode:  MODE_OPAQUE,
      sprite_x:   8'd0,
      sprite_y:   8'd0,
      sprite_w:   9'd1,
      sprite_h:   9'd1,
      swap_color: 16'h0000,
      inv_scale:  24'd65536,
      key_color:  16'hF81F
   };

   // Word leaving the mapping stages.
   typedef struct packed {
      cmd_type              command;
      logic [ATLAS_AW-1:0]  atlas_address;
      logic [COLOR_W-1:0]   store_color;
      logic [9:0]           step_x;
      logic [9:0]           step_y;
      logic [SRC_W-1:0]     src_x;
      logic [SRC_W-1:0]     src_y;
      logic [9:0]           scr_x;
      logic [9:0]           scr_y;
      logic                 on_screen;
   } map_word_type;

endpackage

`default_nettype wire

// ----- sv/sprite_blit_pixel_engine.sv -----
// Top level of the sprite blit pixel engine: handshake, atlas addressing, RAM.
// Depends on sbpe_pkg, sbpe_csr, sbpe_map, sbpe_ram, sbpe_shade, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Sprite blitter with a 65536 x 16 RGB565 atlas. A load word (command 0)
// writes one atlas entry; a draw word (command 1) maps one sprite pixel to
// a framebuffer write, or to nothing when it is clipped, outside the sprite,
// outside the atlas, or filtered by the draw mode. Throughput is one word per
// clock while the result port accepts; a draw passes through these stages in
// order, and rsp_valid rises when it enters stage 4:
//   stage 1  input register
//   stage 2  Q8.16 scale multiplies (one 10x24 per axis), screen clip
//   stage 3  clamp, atlas clip, atlas/framebuffer address, atlas RAM read
//   stage 4  key/black filter, recolor, result register
// Each stage advances when the stage after it is empty or moving, so bubbles
// (loads, dropped pixels) are squeezed out while the result port stalls;
// req_ready falls only when all four stages hold words. A load writes the RAM
// as it leaves stage 2, so a draw accepted right after it reads the new data.
// Atlas contents are undefined after reset until written; there is no
// clearing pass. Configuration takes effect immediately and should be
// written only while the engine is drained.
module sprite_blit_pixel_engine #(
   parameter int ATLAS_WIDTH   = 256,
   parameter int ATLAS_HEIGHT  = 256,
   parameter int SCREEN_WIDTH  = 480,
   parameter int SCREEN_HEIGHT = 480,
   parameter int ROW_STRIDE    = 512
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [sbpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sbpe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request words
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_command,
   input  wire logic [sbpe_pkg::ATLAS_AW-1:0]       req_atlas_address,
   input  wire logic [sbpe_pkg::COLOR_W-1:0]        req_store_color,
   input  wire logic signed [10:0]                  req_dest_x,
   input  wire logic signed [10:0]                  req_dest_y,
   input  wire logic [9:0]                          req_step_x,
   input  wire logic [9:0]                          req_step_y,
   // framebuffer writes
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [sbpe_pkg::FB_W-1:0]                rsp_fb_address,
   output logic [sbpe_pkg::COLOR_W-1:0]             rsp_pixel_color
);

   localparam int AIDX_W = 23;  // 11-bit row * 11-bit width + column
   localparam int FIDX_W = 21;  // 10-bit row * 11-bit stride + column

   sbpe_pkg::csr_type      cfg;
   sbpe_pkg::map_word_type s2;
   logic v1, v2, v3;
   logic adv1, adv2, adv3, adv4;

   logic                           scaled;
   logic [9:0]                     clamp_x, clamp_y, off_x, off_y;
   logic                           ok_x, ok_y;
   logic [10:0]                    ax, ay;
   logic                           in_atlas, draw_ok;
   logic [AIDX_W-1:0]              atlas_idx;
   logic [FIDX_W-1:0]              fb_idx;
   logic                           ram_we;
   logic [sbpe_pkg::COLOR_W-1:0]   ram_rd_data;

   // Ready chain: a stage moves when the next one is free or moving.
   assign adv4      = !rsp_valid || rsp_ready;
   assign adv3      = !v3 || adv4;
   assign adv2      = !v2 || adv3;
   assign adv1      = !v1 || adv2;
   assign req_ready = adv1;

   sbpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbpe_map #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_map (
      .clock             (clock),
      .reset             (reset),
      .s1_en             (adv1),
      .s2_en             (adv2),
      .req_valid         (req_valid),
      .req_command       (req_command),
      .req_atlas_address (req_atlas_address),
      .req_store_color   (req_store_color),
      .req_dest_x        (req_dest_x),
      .req_dest_y        (req_dest_y),
      .req_step_x        (req_step_x),
      .req_step_y        (req_step_y),
      .inv_scale         (cfg.inv_scale),
      .v1                (v1),
      .v2                (v2),
      .s2                (s2)
   );

   // Stage 2 -> 3: source offset, atlas clip and addresses.
   always_comb begin
      scaled = (cfg.draw_mode == sbpe_pkg::MODE_SCALED);

      // nearest-neighbour source clamped to the last sprite pixel
      clamp_x = (s2.src_x >= 18'(cfg.sprite_w)) ? 10'(cfg.sprite_w - 9'd1) : s2.src_x[9:0];
      clamp_y = (s2.src_y >= 18'(cfg.sprite_h)) ? 10'(cfg.sprite_h - 9'd1) : s2.src_y[9:0];
      off_x   = scaled ? clamp_x : s2.step_x;
      off_y   = scaled ? clamp_y : s2.step_y;

      // empty sprite never draws; direct modes also clip to the sprite
      ok_x = (cfg.sprite_w != 9'd0) && (scaled || (s2.step_x < 10'(cfg.sprite_w)));
      ok_y = (cfg.sprite_h != 9'd0) && (scaled || (s2.step_y < 10'(cfg.sprite_h)));

      ax       = 11'(cfg.sprite_x) + 11'(off_x);
      ay       = 11'(cfg.sprite_y) + 11'(off_y);
      in_atlas = (12'(ax) < 12'(ATLAS_WIDTH)) && (12'(ay) < 12'(ATLAS_HEIGHT));

      atlas_idx = AIDX_W'(ay) * AIDX_W'(ATLAS_WIDTH) + AIDX_W'(ax);
      fb_idx    = FIDX_W'(s2.scr_y) * FIDX_W'(ROW_STRIDE) + FIDX_W'(s2.scr_x);

      draw_ok = (s2.command == sbpe_pkg::CMD_DRAW) && ok_x && ok_y
                && s2.on_screen && in_atlas;
   end

   assign ram_we = v2 && adv3 && (s2.command == sbpe_pkg::CMD_LOAD);

   sbpe_ram #(
      .WIDTH (sbpe_pkg::COLOR_W),
      .DEPTH (sbpe_pkg::ATLAS_DEPTH)
   ) u_atlas (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2.atlas_address),
      .wr_data (s2.store_color),
      .rd_en   (adv3),
      .rd_addr (atlas_idx[sbpe_pkg::ATLAS_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   sbpe_shade u_shade (
      .clock           (clock),
      .reset           (reset),
      .s3_en           (adv3),
      .s4_en           (adv4),
      .draw_in         (v2 && draw_ok),
      .fb_in           (fb_idx[sbpe_pkg::FB_W-1:0]),
      .rd_data         (ram_rd_data),
      .cfg             (cfg),
      .v3              (v3),
      .rsp_valid       (rsp_valid),
      .rsp_fb_address  (rsp_fb_address),
      .rsp_pixel_color (rsp_pixel_color)
   );

   // back-pressure reaches the input only with every stage occupied
   `SBPE_ASSERT_NOW(a_full_stall, !req_ready, v1 && v2 && v3 && rsp_valid)
   // a result only ever comes out of an occupied stage 3
   `SBPE_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(v3))
   // a stage-1 word blocked by stage 2 is kept
   `SBPE_ASSERT_NEXT(a_s1_hold, v1 && !adv2, v1)

endmodule

`default_nettype wire

// ----- sv/sbpe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/sbpe_csr.sv -----
// Configuration register file of the sprite blit engine.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [sbpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sbpe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sbpe_pkg::csr_type                        cfg
);

   sbpe_pkg::csr_type cfg_ff;
   sbpe_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (sbpe_pkg::csr_index_type'(csr_index))
            sbpe_pkg::CSR_DRAW_MODE:
               cfg_in.draw_mode = sbpe_pkg::draw_mode_type'(csr_wdata[1:0]);
            sbpe_pkg::CSR_SPRITE_X:   cfg_in.sprite_x   = csr_wdata[7:0];
            sbpe_pkg::CSR_SPRITE_Y:   cfg_in.sprite_y   = csr_wdata[7:0];
            sbpe_pkg::CSR_SPRITE_W:   cfg_in.sprite_w   = csr_wdata[8:0];
            sbpe_pkg::CSR_SPRITE_H:   cfg_in.sprite_h   = csr_wdata[8:0];
            sbpe_pkg::CSR_SWAP_COLOR: cfg_in.swap_color = csr_wdata[15:0];
            sbpe_pkg::CSR_INV_SCALE:  cfg_in.inv_scale  = csr_wdata[23:0];
            sbpe_pkg::CSR_KEY_COLOR:  cfg_in.key_color  = csr_wdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sbpe_pkg::CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- sv/sbpe_map.sv -----
// Stages 1 and 2: input register, scale multiplies and screen position/clip.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_map #(
   parameter int SCREEN_WIDTH  = 480,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             s1_en,
   input  wire logic                             s2_en,
   input  wire logic                             req_valid,
   input  wire logic                             req_command,
   input  wire logic [sbpe_pkg::ATLAS_AW-1:0]    req_atlas_address,
   input  wire logic [sbpe_pkg::COLOR_W-1:0]     req_store_color,
   input  wire logic signed [10:0]               req_dest_x,
   input  wire logic signed [10:0]               req_dest_y,
   input  wire logic [9:0]                       req_step_x,
   input  wire logic [9:0]                       req_step_y,
   input  wire logic [23:0]                      inv_scale,
   output logic                                  v1,
   output logic                                  v2,
   output sbpe_pkg::map_word_type                s2
);

   typedef struct packed {
      sbpe_pkg::cmd_type                command;
      logic [sbpe_pkg::ATLAS_AW-1:0]    atlas_address;
      logic [sbpe_pkg::COLOR_W-1:0]     store_color;
      logic signed [10:0]               dest_x;
      logic signed [10:0]               dest_y;
      logic [9:0]                       step_x;
      logic [9:0]                       step_y;
   } in_word_type;

   logic                   v1_ff, v2_ff;
   in_word_type            s1_ff;
   sbpe_pkg::map_word_type s2_ff, s2_in;

   logic [33:0]        prod_x, prod_y;
   logic signed [12:0] scr_x, scr_y;
   logic               on_x, on_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            v1_ff <= req_valid;
         end
         if (s2_en) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff.command       <= sbpe_pkg::cmd_type'(req_command);
         s1_ff.atlas_address <= req_atlas_address;
         s1_ff.store_color   <= req_store_color;
         s1_ff.dest_x        <= req_dest_x;
         s1_ff.dest_y        <= req_dest_y;
         s1_ff.step_x        <= req_step_x;
         s1_ff.step_y        <= req_step_y;
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
   end

   // Q8.16 scale: one 10x24 multiplier per axis
   always_comb begin
      prod_x = 34'(s1_ff.step_x) * 34'(inv_scale);
      prod_y = 34'(s1_ff.step_y) * 34'(inv_scale);
      scr_x  = 13'(s1_ff.dest_x) + $signed({3'b000, s1_ff.step_x});
      scr_y  = 13'(s1_ff.dest_y) + $signed({3'b000, s1_ff.step_y});
      on_x   = !scr_x[12] && (scr_x[11:0] < 12'(SCREEN_WIDTH));
      on_y   = !scr_y[12] && (scr_y[11:0] < 12'(SCREEN_HEIGHT));

      s2_in.command       = s1_ff.command;
      s2_in.atlas_address = s1_ff.atlas_address;
      s2_in.store_color   = s1_ff.store_color;
      s2_in.step_x        = s1_ff.step_x;
      s2_in.step_y        = s1_ff.step_y;
      s2_in.src_x         = prod_x[33:16];
      s2_in.src_y         = prod_y[33:16];
      s2_in.scr_x         = scr_x[9:0];
      s2_in.scr_y         = scr_y[9:0];
      s2_in.on_screen     = on_x && on_y;
   end

   assign v1 = v1_ff;
   assign v2 = v2_ff;
   assign s2 = s2_ff;

endmodule

`default_nettype wire

// ----- sv/sbpe_shade.sv -----
// Stages 3 and 4: color-key/black filter and recolor on atlas data, and the result register.
// Depends on sbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_shade (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             s3_en,
   input  wire logic                             s4_en,
   input  wire logic                             draw_in,
   input  wire logic [sbpe_pkg::FB_W-1:0]        fb_in,
   input  wire logic [sbpe_pkg::COLOR_W-1:0]     rd_data,
   input  sbpe_pkg::csr_type                     cfg,
   output logic                                  v3,
   output logic                                  rsp_valid,
   output logic [sbpe_pkg::FB_W-1:0]             rsp_fb_address,
   output logic [sbpe_pkg::COLOR_W-1:0]          rsp_pixel_color
);

   logic                          v3_ff, v4_ff;
   logic [sbpe_pkg::FB_W-1:0]     fb3_ff, fb4_ff;
   logic [sbpe_pkg::COLOR_W-1:0]  color4_ff;
   logic                          keep;
   logic [sbpe_pkg::COLOR_W-1:0]  color;

   always_comb begin
      keep  = 1'b1;
      color = rd_data;
      case (cfg.draw_mode) inside
         sbpe_pkg::MODE_OPAQUE: begin
            keep = 1'b1;
         end
         sbpe_pkg::MODE_KEYED: begin
            keep = (rd_data != cfg.key_color) && (rd_data != sbpe_pkg::BLACK_565);
         end
         sbpe_pkg::MODE_RECOLOR, sbpe_pkg::MODE_SCALED: begin
            keep = (rd_data != sbpe_pkg::BLACK_565);
            if (rd_data == cfg.key_color) begin
               color = cfg.swap_color;
            end
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (s3_en) begin
            v3_ff <= draw_in;
         end
         if (s4_en) begin
            v4_ff <= v3_ff && keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         fb3_ff <= fb_in;
      end
      if (s4_en) begin
         fb4_ff    <= fb3_ff;
         color4_ff <= color;
      end
   end

   assign v3              = v3_ff;
   assign rsp_valid       = v4_ff;
   assign rsp_fb_address  = fb4_ff;
   assign rsp_pixel_color = color4_ff;

endmodule

`default_nettype wire
